// ===== rtl/k_way_sorted_merge_defines.svh =====
// Assertion macros used by the k-way sorted merge RTL.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define KWSM_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define KWSM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KWSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwsm_pkg.sv =====
// Types and codes of the k-way sorted merge.
`default_nettype none

package kwsm_pkg;

  localparam int KEY_W     = 64;
  localparam int TAG_W     = 32;
  localparam int RUN_IDX_W = 3;

  typedef logic [RUN_IDX_W-1:0] run_idx_t;

  // Request operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_EMIT    = 2'd0;
  localparam logic [1:0] ST_DRAINED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    run_idx_t         run_index;
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] record_tag;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    run_idx_t         out_run;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/kwsm_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module kwsm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/k_way_sorted_merge.sv =====
// k-way sorted merge: usage
//   Request channel (item_valid / item_stall / item) carries load, pull and
//   clear requests. Result channel (result_valid / result_stall / result)
//   returns one result for a pull or a rejected load; accepted loads, clears
//   and undefined operations return nothing.
//   A request is taken into an input register and handled from there unless
//   stalled; its result is then written into the output register.
//   Loads and clears need no refill. A pull whose emitted run still holds
//   records also refills: the run's next record is read from the record RAM
//   (registered read) into that run's head register.
//   The smallest head is found by a compare tree over the per-run head
//   registers, log2(NUM_RUNS) levels deep; ties go to the lower run.
//   item_stall rises while the head refill is pending, or while the held
//   request must write a result and the output register is full and stalled.
//   A waiting result does not block loads that produce none.
//   Reset (rst, synchronous) empties all runs, drops any held request and
//   result; the record RAM is not cleared and needs no clearing pass.
//   A clear request empties all runs.
`include "k_way_sorted_merge_defines.svh"
`default_nettype none

module k_way_sorted_merge #(
  parameter int NUM_RUNS  = 8,
  parameter int RUN_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire kwsm_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output kwsm_pkg::result_t     result
);

  localparam int KEY_W     = kwsm_pkg::KEY_W;
  localparam int TAG_W     = kwsm_pkg::TAG_W;
  localparam int RECW      = KEY_W + TAG_W;
  localparam int RW        = $clog2(NUM_RUNS);
  localparam int CW        = $clog2(RUN_DEPTH + 1);
  localparam int DEPTH_ALL = NUM_RUNS * RUN_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);
  localparam int NP        = 1 << RW;

  // Input register
  kwsm_pkg::item_t item_q;
  logic            item_held;

  // Per-run state: fill counts, read positions, head records
  logic [CW-1:0]   fill_cnt [NUM_RUNS];
  logic [CW-1:0]   rd_pos   [NUM_RUNS];
  logic [RECW-1:0] head_rec [NUM_RUNS];
  logic [NUM_RUNS-1:0] nonempty;
  logic [NUM_RUNS-1:0] pos_ok;

  // Head refill
  logic          fetch;
  logic [RW-1:0] fetch_run;

  // Record RAM ports
  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [RECW-1:0] ram_rd_data;

  // Compare tree
  logic             leaf_vld  [NP];
  logic [KEY_W-1:0] leaf_key  [NP];
  logic [TAG_W-1:0] leaf_tag  [NP];
  logic [RW-1:0]    leaf_run  [NP];
  logic [CW-1:0]    leaf_pos  [NP];
  logic [CW-1:0]    leaf_fill [NP];
  logic             node_vld  [2*NP];
  logic [KEY_W-1:0] node_key  [2*NP];
  logic [TAG_W-1:0] node_tag  [2*NP];
  logic [RW-1:0]    node_run  [2*NP];
  logic [CW-1:0]    node_pos  [2*NP];
  logic [CW-1:0]    node_fill [2*NP];

  logic             best_found;
  logic [KEY_W-1:0] best_key;
  logic [TAG_W-1:0] best_tag;
  logic [RW-1:0]    best_run;
  logic [CW-1:0]    best_pos;
  logic [CW-1:0]    best_fill;
  logic [CW-1:0]    pull_next_pos;
  logic             has_next;

  // Decode of the held request
  logic          is_load, is_pull, is_clear;
  logic          run_ok, load_full, load_ok;
  logic [RW-1:0] ld_run;
  logic          ld_empty;
  logic          proceed, res_gen;
  logic          do_load, do_pull, do_clear, do_fetch;
  kwsm_pkg::result_t result_next;

  // Per-run status and tree leaves
  for (genvar r = 0; r < NP; r++) begin : g_leaf
    if (r < NUM_RUNS) begin : g_run
      assign nonempty[r]  = rd_pos[r] != fill_cnt[r];
      assign pos_ok[r]    = rd_pos[r] <= fill_cnt[r];
      assign leaf_vld[r]  = nonempty[r];
      assign leaf_key[r]  = head_rec[r][RECW-1:TAG_W];
      assign leaf_tag[r]  = head_rec[r][TAG_W-1:0];
      assign leaf_run[r]  = RW'(r);
      assign leaf_pos[r]  = rd_pos[r];
      assign leaf_fill[r] = fill_cnt[r];
    end else begin : g_pad
      assign leaf_vld[r]  = 1'b0;
      assign leaf_key[r]  = '0;
      assign leaf_tag[r]  = '0;
      assign leaf_run[r]  = '0;
      assign leaf_pos[r]  = '0;
      assign leaf_fill[r] = '0;
    end
  end

  // Min-key tree: left child (lower run) wins on equal keys
  always_comb begin
    for (int n = 0; n < NP; n++) begin
      node_vld[n]  = 1'b0;
      node_key[n]  = '0;
      node_tag[n]  = '0;
      node_run[n]  = '0;
      node_pos[n]  = '0;
      node_fill[n] = '0;
    end
    for (int n = 0; n < NP; n++) begin
      node_vld[NP+n]  = leaf_vld[n];
      node_key[NP+n]  = leaf_key[n];
      node_tag[NP+n]  = leaf_tag[n];
      node_run[NP+n]  = leaf_run[n];
      node_pos[NP+n]  = leaf_pos[n];
      node_fill[NP+n] = leaf_fill[n];
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (node_vld[2*n+1] && (!node_vld[2*n] || node_key[2*n+1] < node_key[2*n])) begin
        node_vld[n]  = node_vld[2*n+1];
        node_key[n]  = node_key[2*n+1];
        node_tag[n]  = node_tag[2*n+1];
        node_run[n]  = node_run[2*n+1];
        node_pos[n]  = node_pos[2*n+1];
        node_fill[n] = node_fill[2*n+1];
      end else begin
        node_vld[n]  = node_vld[2*n];
        node_key[n]  = node_key[2*n];
        node_tag[n]  = node_tag[2*n];
        node_run[n]  = node_run[2*n];
        node_pos[n]  = node_pos[2*n];
        node_fill[n] = node_fill[2*n];
      end
    end
  end

  assign best_found    = node_vld[1];
  assign best_key      = node_key[1];
  assign best_tag      = node_tag[1];
  assign best_run      = node_run[1];
  assign best_pos      = node_pos[1];
  assign best_fill     = node_fill[1];
  assign pull_next_pos = best_pos + 1'b1;
  assign has_next      = pull_next_pos != best_fill;

  // Request decode and load checks
  assign is_load   = item_q.operation == kwsm_pkg::OP_LOAD;
  assign is_pull   = item_q.operation == kwsm_pkg::OP_PULL;
  assign is_clear  = item_q.operation == kwsm_pkg::OP_CLEAR;
  assign run_ok    = int'(item_q.run_index) < NUM_RUNS;
  assign ld_run    = RW'(item_q.run_index);
  assign load_full = fill_cnt[ld_run] == CW'(RUN_DEPTH);
  assign ld_empty  = !nonempty[ld_run];
  assign load_ok   = run_ok && !load_full;

  // Handshake: hold off during a refill or when the result slot is blocked
  assign proceed    = item_held && !fetch && (!res_gen || !result_valid || !result_stall);
  assign item_stall = item_held && !proceed;
  assign res_gen    = (is_load && !load_ok) || is_pull;

  assign do_load  = proceed && is_load && load_ok;
  assign do_pull  = proceed && is_pull && best_found;
  assign do_clear = proceed && is_clear;
  assign do_fetch = do_pull && has_next;

  // Record RAM addressing
  assign ram_wr_en   = do_load;
  assign ram_wr_addr = AW'(ld_run) * AW'(RUN_DEPTH) + AW'(fill_cnt[ld_run]);
  assign ram_rd_en   = do_fetch;
  assign ram_rd_addr = AW'(best_run) * AW'(RUN_DEPTH) + AW'(pull_next_pos);

  kwsm_ram #(
    .WIDTH (RECW),
    .DEPTH (DEPTH_ALL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data ({item_q.sort_key, item_q.record_tag}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result formatting
  always_comb begin
    result_next = '0;
    if (is_pull) begin
      if (best_found) begin
        result_next.status  = kwsm_pkg::ST_EMIT;
        result_next.out_key = best_key;
        result_next.out_tag = best_tag;
        result_next.out_run = kwsm_pkg::run_idx_t'(best_run);
      end else begin
        result_next.status = kwsm_pkg::ST_DRAINED;
      end
    end else begin
      result_next.status  = kwsm_pkg::ST_FULL;
      result_next.out_run = item_q.run_index;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_held <= 1'b1;
    end else if (proceed) begin
      item_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proceed && res_gen) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_gen) begin
      result <= result_next;
    end
  end

  // Fill counts and read positions
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int r = 0; r < NUM_RUNS; r++) begin
        fill_cnt[r] <= '0;
        rd_pos[r]   <= '0;
      end
    end else begin
      for (int r = 0; r < NUM_RUNS; r++) begin
        if (do_load && ld_run == RW'(r)) begin
          fill_cnt[r] <= fill_cnt[r] + 1'b1;
        end
        if (do_pull && best_run == RW'(r)) begin
          rd_pos[r] <= pull_next_pos;
        end
      end
    end
  end

  // Head refill control
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch <= 1'b0;
    end else begin
      fetch <= do_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fetch) begin
      fetch_run <= best_run;
    end
  end

  // Head records: refilled from RAM, or loaded directly into an empty run
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_RUNS; r++) begin
      if (fetch && fetch_run == RW'(r)) begin
        head_rec[r] <= ram_rd_data;
      end else if (do_load && ld_empty && ld_run == RW'(r)) begin
        head_rec[r] <= {item_q.sort_key, item_q.record_tag};
      end
    end
  end

  // Checks
  `KWSM_ASSERT_HOLDS(a_pos_within_fill, &pos_ok, "read position passed fill count")
  `KWSM_ASSERT_NEXT(a_fetch_one_cycle, fetch, !fetch, "head refill lasted over one cycle")
  `KWSM_ASSERT_IMPLIES(a_emit_live_run, do_pull, best_pos != best_fill, "emitted an empty run")

endmodule

`default_nettype wire
